// ----- design/binary_min_heap_queue_core_assert.svh -----
// assertion macros shared by the heap queue checker
// each macro expands to one labeled concurrent assertion
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define BMHQ_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BMHQ_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

`endif

// ----- design/bmhq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmhq_pkg
// Types and constants shared by the binary min-heap queue modules.
// ---------------------------------------------------------------------------
package bmhq_pkg;

   localparam int KEY_W   = 32;
   localparam int COUNT_W = 7;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_PROMOTE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      kind_type                kind;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] removed_key;
      status_type              status;
      logic [COUNT_W-1:0]      count;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [KEY_W-1:0] tag;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RM_LOAD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_UP_RD,
      ST_UP_CMP,
      ST_SCAN
   } state_type;

   typedef enum logic {
      DIR_UP,
      DIR_DOWN
   } sift_dir_type;

   typedef struct packed {
      sift_dir_type            dir;
      logic signed [KEY_W-1:0] mov_key;
      logic signed [KEY_W-1:0] key_a;
      logic signed [KEY_W-1:0] key_b;
      logic                    b_ok;
   } step_req_type;

   typedef struct packed {
      logic move;
      logic pick_b;
   } step_rsp_type;

endpackage

// ----- design/bmhq_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmhq_mem
// Heap entry store: one write port, two read ports with registered data.
// ---------------------------------------------------------------------------
module bmhq_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  bmhq_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output bmhq_pkg::entry_type rd_data_a,
   output bmhq_pkg::entry_type rd_data_b
);
   import bmhq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- design/bmhq_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmhq_step
// Shared sift decision unit: one signed compare for a sift-up step, or a
// pick of the smallest of the moving entry and its two children.
// ---------------------------------------------------------------------------
module bmhq_step (
   input  bmhq_pkg::step_req_type step_req,
   output bmhq_pkg::step_rsp_type step_rsp
);
   import bmhq_pkg::*;

   logic signed [KEY_W-1:0] cmp_x;
   logic signed [KEY_W-1:0] cmp_y;
   logic signed [KEY_W-1:0] best_key;
   logic                    lt_first;
   logic                    lt_second;

   // up: moving key below parent; down: left child below moving key
   assign cmp_x    = (step_req.dir == DIR_UP) ? step_req.mov_key : step_req.key_a;
   assign cmp_y    = (step_req.dir == DIR_UP) ? step_req.key_a : step_req.mov_key;
   assign lt_first = cmp_x < cmp_y;
   assign best_key = lt_first ? step_req.key_a : step_req.mov_key;
   assign lt_second = step_req.b_ok && (step_req.key_b < best_key);

   always_comb begin
      step_rsp = '0;
      case (step_req.dir)
         DIR_UP: begin
            step_rsp.move   = lt_first;
            step_rsp.pick_b = 1'b0;
         end
         DIR_DOWN: begin
            step_rsp.move   = lt_first | lt_second;
            step_rsp.pick_b = lt_second;
         end
         default: begin
            step_rsp = '0;
         end
      endcase
   end

endmodule

// ----- design/binary_min_heap_queue_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_min_heap_queue_core
// Binary min-heap priority queue with insert, remove-minimum and promote.
// ---------------------------------------------------------------------------
// usage
//   a request is taken when start is high and busy is low; req_data carries
//   the kind and key. exactly one result per request appears on rsp_data for
//   a single cycle with rsp_strobe high; the receiver cannot hold it off.
// sequence (the result shows in the first cycle busy is low)
//   full insert, empty remove, promote on empty and the unused kind answer
//   in the cycle after the request with no busy time.
//   insert: a read step and a compare step per level climbed, ending when
//   it reaches the root or stops lower.
//   remove: a load of the root and last entry (done there if it was the
//   only one), then a read step and a compare step per level sunk, ending
//   at a leaf or when it stops higher.
//   promote: one entry scanned per cycle from the last position toward the
//   root until the tag matches (up to count), then a sift-up as for insert.
//   a new request is taken in the cycle the result shows. the rate is set by
//   the single entry memory and the one shared compare unit.
// reset
//   clears the entry count and the sequencer; the entry memory is not
//   cleared, entries become valid as the count grows over them.
// ---------------------------------------------------------------------------
module binary_min_heap_queue_core #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bmhq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output bmhq_pkg::rsp_type rsp_data
);
   import bmhq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pos_ff, pos_in;
   entry_type               mov_ff, mov_in;
   logic signed [KEY_W-1:0] target_ff, target_in;
   logic signed [KEY_W-1:0] removed_ff, removed_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   entry_type               wr_data;
   logic [AW-1:0]           rd_addr_a;
   logic [AW-1:0]           rd_addr_b;
   entry_type               rd_data_a;
   entry_type               rd_data_b;

   step_req_type            step_req;
   step_rsp_type            step_rsp;

   logic                    done;
   status_type              status_code;
   logic [CW:0]             child_l;
   logic [CW:0]             child_r;
   logic signed [KEY_W-1:0] promo_key;

   bmhq_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   bmhq_step u_step (
      .step_req (step_req),
      .step_rsp (step_rsp)
   );

   assign child_l   = {pos_ff, 1'b0};
   assign child_r   = {pos_ff, 1'b1};
   // root key minus one, held at the most negative key
   assign promo_key = (rd_data_b.key == KEY_MIN) ? rd_data_b.key : rd_data_b.key - 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      mov_ff     <= mov_in;
      target_ff  <= target_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      mov_in        = mov_ff;
      target_in     = target_ff;
      removed_in    = removed_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(pos_ff - 1'b1);
      wr_data       = mov_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      done          = 1'b0;
      status_code   = STATUS_OK;
      step_req.dir     = DIR_UP;
      step_req.mov_key = mov_ff.key;
      step_req.key_a   = rd_data_a.key;
      step_req.key_b   = rd_data_b.key;
      step_req.b_ok    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               removed_in = '0;
               target_in  = req_data.key;
               case (req_data.kind)
                  KIND_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        done        = 1'b1;
                        status_code = STATUS_FULL;
                     end else begin
                        count_in   = count_ff + 1'b1;
                        pos_in     = count_ff + 1'b1;
                        mov_in.key = req_data.key;
                        mov_in.tag = req_data.key;
                        state_in   = ST_UP_RD;
                     end
                  end
                  KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        status_code = STATUS_EMPTY;
                     end else begin
                        rd_addr_a = '0;
                        rd_addr_b = AW'(count_ff - 1'b1);
                        state_in  = ST_RM_LOAD;
                     end
                  end
                  KIND_PROMOTE: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        status_code = STATUS_NOT_FOUND;
                     end else begin
                        pos_in    = count_ff;
                        rd_addr_a = AW'(count_ff - 1'b1);
                        rd_addr_b = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_RM_LOAD: begin
            removed_in = rd_data_a.key;
            mov_in     = rd_data_b;
            count_in   = count_ff - 1'b1;
            pos_in     = CW'(1);
            if (count_ff == CW'(1)) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DN_RD;
            end
         end
         ST_DN_RD: begin
            if (child_l > {1'b0, count_ff}) begin
               wr_en    = 1'b1;
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_addr_a = AW'(child_l - 1'b1);
               rd_addr_b = AW'(child_l);
               state_in  = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            step_req.dir  = DIR_DOWN;
            step_req.b_ok = child_r <= {1'b0, count_ff};
            wr_en         = 1'b1;
            if (step_rsp.move) begin
               wr_data  = step_rsp.pick_b ? rd_data_b : rd_data_a;
               pos_in   = step_rsp.pick_b ? CW'(child_r) : CW'(child_l);
               state_in = ST_DN_RD;
            end else begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_UP_RD: begin
            if (pos_ff == CW'(1)) begin
               wr_en    = 1'b1;
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_addr_a = AW'((pos_ff >> 1) - 1'b1);
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            step_req.dir = DIR_UP;
            wr_en        = 1'b1;
            if (step_rsp.move) begin
               wr_data  = rd_data_a;
               pos_in   = pos_ff >> 1;
               state_in = ST_UP_RD;
            end else begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // port a walks down from the last position, port b holds the root
            rd_addr_b = '0;
            if (rd_data_a.tag == target_ff) begin
               mov_in.key = promo_key;
               mov_in.tag = rd_data_a.tag;
               state_in   = ST_UP_RD;
            end else if (pos_ff == CW'(1)) begin
               done        = 1'b1;
               status_code = STATUS_NOT_FOUND;
               state_in    = ST_IDLE;
            end else begin
               pos_in    = pos_ff - 1'b1;
               rd_addr_a = AW'(pos_ff - 2'd2);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_strobe_in      = done;
      rsp_in.removed_key = removed_in;
      rsp_in.status      = status_code;
      rsp_in.count       = COUNT_W'(count_in);
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- design/bmhq_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmhq_checker
// Port-level checks on the heap queue request and result behavior.
// ---------------------------------------------------------------------------
`include "binary_min_heap_queue_core_assert.svh"

module bmhq_checker #(
   parameter int CAPACITY = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bmhq_pkg::req_type req_data,
   input logic              rsp_strobe,
   input bmhq_pkg::rsp_type rsp_data
);
   import bmhq_pkg::*;

   // an accepted request either answers at once or holds busy
   `BMHQ_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe, "request neither started nor answered")
   // leaving busy always comes with a result
   `BMHQ_ASSERT_NEXT(a_busy_exit, clock, reset, busy, busy || rsp_strobe, "busy dropped without a result")
   `BMHQ_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result shown while busy")
   `BMHQ_ASSERT_NOW(a_empty_shape, clock, reset, rsp_strobe && rsp_data.status == STATUS_EMPTY, rsp_data.count == '0 && rsp_data.removed_key == '0, "empty result with entries or a key")
   `BMHQ_ASSERT_NOW(a_full_shape, clock, reset, rsp_strobe && rsp_data.status == STATUS_FULL, rsp_data.count == COUNT_W'(CAPACITY), "full result below capacity")

endmodule

bind binary_min_heap_queue_core bmhq_checker #(
   .CAPACITY (CAPACITY)
) u_bmhq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
